>>> hdl/ira_pkg.sv
// ira_pkg: shared types and constants of the identifier range allocator
package ira_pkg;

	localparam int ID_W    = 10;   // width of identifiers and start index
	localparam int WORD_W  = 16;   // flags per map memory word
	localparam int BIT_W   = 4;    // bit select within one map word
	localparam int SUM_W   = 18;   // holds any identifier bound plus any map index

	typedef enum logic {
		FN_ALLOC   = 1'b0,
		FN_RELEASE = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DISABLED  = 3'd1,
		ST_FULL      = 3'd2,
		ST_RANGE     = 3'd3,
		ST_NOT_ALLOC = 3'd4
	} status_t;

	typedef struct packed {
		func_t            func;
		logic [ID_W-1:0]  release_id;
		logic [ID_W-1:0]  start_index;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  id;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_REDUCE,
		S_SCAN,
		S_REL_RD,
		S_REL_CHK,
		S_FINISH
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic    clr_step;
		logic    latch;
		logic    reduce_step;
		logic    scan_start;
		logic    scan_step;
		logic    mark;
		logic    rel_read;
		logic    rel_clear;
		logic    set_res;
		status_t res_code;
		logic    load_out;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic map_en;
		logic is_alloc;
		logic full;
		logic in_range;
		logic idx_big;
		logic found;
		logic rel_used;
		logic out_free;
	} dp_stat_t;

endpackage

>>> hdl/ira_if.sv
// ira_if: handshake channels of the identifier range allocator

interface ira_req_if ();
	logic          valid;
	logic          ready;
	ira_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ira_rsp_if ();
	logic          valid;
	logic          ready;
	ira_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ira_cfg_if ();
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ira_ram.sv
// ira_ram: generic single write, single read memory with registered read data
module ira_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/ira_dp.sv
// ira_dp: flag map memory, scan pipeline, counters and result registers
module ira_dp #(
	parameter int LOW_ID  = 100,
	parameter int HIGH_ID = 1000
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ira_pkg::ctrl_cmd_t cmd,
	output ira_pkg::dp_stat_t  stat,
	input  ira_pkg::req_t      req_data,
	input  logic               cfg_valid,
	input  logic               cfg_data,
	output logic               cfg_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output ira_pkg::rsp_t      rsp_data
);
	import ira_pkg::*;

	localparam int MAP_DEPTH = HIGH_ID - LOW_ID + 1;
	localparam int NUM_WORDS = (MAP_DEPTH + WORD_W - 1) / WORD_W;
	localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int IDX_W     = (((WADDR_W + BIT_W) > ID_W) ? (WADDR_W + BIT_W) : ID_W) + 1;
	localparam int CNT_W     = $clog2(MAP_DEPTH + 1);

	logic                map_en_q;
	logic [CNT_W-1:0]    count_q;
	logic [WADDR_W-1:0]  clr_addr_q;
	func_t               func_q;
	logic [ID_W-1:0]     rel_id_q;
	logic [IDX_W-1:0]    idx_q;
	logic [WADDR_W-1:0]  scan_addr_q;
	logic [BIT_W-1:0]    scan_bit_q;
	logic                first_q;
	logic                rd_vld_s1;
	logic                first_s1;
	logic [WADDR_W-1:0]  addr_s1;
	status_t             res_status_q;
	logic [ID_W-1:0]     res_id_q;
	logic                rsp_vld_q;
	rsp_t                rsp_q;

	logic [IDX_W-1:0]    rel_idx;
	logic [WADDR_W-1:0]  rel_word;
	logic [BIT_W-1:0]    rel_bit;
	logic [WORD_W-1:0]   rdata;
	logic [WORD_W-1:0]   free;
	logic [BIT_W-1:0]    pos;
	logic [IDX_W-1:0]    found_idx;
	logic [SUM_W-1:0]    id_sum;
	logic                we;
	logic [WADDR_W-1:0]  waddr;
	logic [WORD_W-1:0]   wdata;
	logic                re;
	logic [WADDR_W-1:0]  raddr;
	logic [SUM_W-1:0]    rel_wide;

	assign cfg_ready = 1'b1;

	assign rel_idx  = IDX_W'(rel_id_q) - IDX_W'(LOW_ID);
	assign rel_word = rel_idx[BIT_W +: WADDR_W];
	assign rel_bit  = rel_idx[BIT_W-1:0];
	assign rel_wide = SUM_W'(rel_id_q);

	// free flags of the word under inspection, lowest one wins
	always_comb begin
		free = '0;
		pos  = '0;
		for (int b = 0; b < WORD_W; b++) begin
			free[b] = !rdata[b]
				&& (IDX_W'({addr_s1, BIT_W'(b)}) < IDX_W'(MAP_DEPTH))
				&& (!first_s1 || (BIT_W'(b) >= scan_bit_q));
		end
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (free[b]) begin
				pos = BIT_W'(b);
			end
		end
	end

	assign found_idx = IDX_W'({addr_s1, pos});
	assign id_sum    = SUM_W'(LOW_ID) + SUM_W'(found_idx);

	assign stat.clr_done = (clr_addr_q == WADDR_W'(NUM_WORDS - 1));
	assign stat.map_en   = map_en_q;
	assign stat.is_alloc = (func_q == FN_ALLOC);
	assign stat.full     = (count_q >= CNT_W'(MAP_DEPTH));
	assign stat.in_range = (rel_wide >= SUM_W'(LOW_ID)) && (rel_wide <= SUM_W'(HIGH_ID));
	assign stat.idx_big  = (idx_q >= IDX_W'(MAP_DEPTH));
	assign stat.found    = rd_vld_s1 && (|free);
	assign stat.rel_used = rdata[rel_bit];
	assign stat.out_free = !rsp_vld_q || rsp_ready;

	// memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = clr_addr_q;
		wdata = '0;
		re    = 1'b0;
		raddr = scan_addr_q;
		if (cmd.mark) begin
			we    = 1'b1;
			waddr = addr_s1;
			wdata = rdata | (WORD_W'(1) << pos);
		end else if (cmd.rel_clear) begin
			we    = 1'b1;
			waddr = rel_word;
			wdata = rdata & ~(WORD_W'(1) << rel_bit);
		end else if (cmd.clr_step) begin
			we    = 1'b1;
		end
		if (cmd.scan_step) begin
			re = 1'b1;
		end else if (cmd.rel_read) begin
			re    = 1'b1;
			raddr = rel_word;
		end
	end

	ira_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_WORDS)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_en_q   <= 1'b0;
			count_q    <= '0;
			clr_addr_q <= '0;
			rd_vld_s1  <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				map_en_q <= cfg_data;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.mark) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.rel_clear && (count_q != '0)) begin
				count_q <= count_q - 1'b1;
			end
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.load_out) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q   <= req_data.func;
			rel_id_q <= req_data.release_id;
			idx_q    <= IDX_W'(req_data.start_index);
		end else if (cmd.reduce_step) begin
			idx_q <= idx_q - IDX_W'(MAP_DEPTH);
		end
		if (cmd.scan_start) begin
			scan_addr_q <= idx_q[BIT_W +: WADDR_W];
			scan_bit_q  <= idx_q[BIT_W-1:0];
			first_q     <= 1'b1;
		end else if (cmd.scan_step) begin
			scan_addr_q <= (scan_addr_q == WADDR_W'(NUM_WORDS - 1)) ? '0
				: scan_addr_q + 1'b1;
			first_q     <= 1'b0;
		end
		if (cmd.scan_step) begin
			addr_s1  <= scan_addr_q;
			first_s1 <= first_q;
		end
		if (cmd.mark) begin
			res_status_q <= ST_OK;
			res_id_q     <= id_sum[ID_W-1:0];
		end else if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_id_q     <= '0;
		end
		if (cmd.load_out) begin
			rsp_q.status <= res_status_q;
			rsp_q.id     <= res_id_q;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_q;

endmodule

>>> hdl/ira_ctrl.sv
// ira_ctrl: request sequencer of the identifier range allocator
module ira_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  ira_pkg::dp_stat_t  stat,
	output ira_pkg::ctrl_cmd_t cmd
);
	import ira_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.res_code = ST_OK;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!stat.map_en) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_DISABLED;
					state_d      = S_FINISH;
				end else if (stat.is_alloc) begin
					if (stat.full) begin
						cmd.set_res  = 1'b1;
						cmd.res_code = ST_FULL;
						state_d      = S_FINISH;
					end else begin
						state_d = S_REDUCE;
					end
				end else if (!stat.in_range) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_RANGE;
					state_d      = S_FINISH;
				end else begin
					state_d = S_REL_RD;
				end
			end
			S_REDUCE: begin
				if (stat.idx_big) begin
					cmd.reduce_step = 1'b1;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.found) begin
					cmd.mark = 1'b1;
					state_d  = S_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_REL_RD: begin
				cmd.rel_read = 1'b1;
				state_d      = S_REL_CHK;
			end
			S_REL_CHK: begin
				cmd.set_res = 1'b1;
				if (stat.rel_used) begin
					cmd.rel_clear = 1'b1;
					cmd.res_code  = ST_OK;
				end else begin
					cmd.res_code = ST_NOT_ALLOC;
				end
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/id_range_allocator.sv
// id_range_allocator: top level of the identifier allocator
// Hands out identifiers LOW_ID..HIGH_ID (100..1000 by default) and takes them back.
// A used-flag map of HIGH_ID-LOW_ID+1 flags sits in a memory of 16-bit words
// (57 words by default). After reset the block sweeps that memory to all free,
// one word per cycle, and holds req.ready low meanwhile; configuration writes are
// taken at any time. Write map_enabled to 1 before use: while it is 0 every
// request answers "map not enabled" and changes nothing. An allocate request
// searches circularly for the first free flag from its start_index (reduced
// modulo the map size), marks it used and returns LOW_ID + index, or answers
// "none free". A release request checks the range, then clears the flag or
// answers "not allocated". Exactly one result per item.
// Sequencing: one item is worked at a time. An allocate reads map words one after
// another, paced by the single read port of the map memory: up to 58 words by
// default (a start_index at or above the map size first has the map size
// subtracted until it lies below it). A release reads the word of its flag, then
// checks it. The result sits in an output register, so the next item is accepted
// while an earlier result still waits to be taken.
module id_range_allocator #(
	parameter int LOW_ID  = 100,
	parameter int HIGH_ID = 1000
) (
	input  logic       clk,
	input  logic       arst_n,
	ira_cfg_if.sink    cfg,
	ira_req_if.sink    req,
	ira_rsp_if.source  rsp
);
	import ira_pkg::*;

	// command and status between sequencer and datapath
	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      req_ready;
	logic      cfg_ready;
	logic      rsp_valid;
	rsp_t      rsp_data;

	// sequencer: clearing sweep, decode, scan, release and result hand-off
	ira_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: flag memory, counters, map_enabled register, output register
	ira_dp #(
		.LOW_ID  (LOW_ID),
		.HIGH_ID (HIGH_ID)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_data  (req.data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.cfg_ready (cfg_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp_data)
	);

	// channel hookup
	assign req.ready = req_ready;
	assign cfg.ready = cfg_ready;
	assign rsp.valid = rsp_valid;
	assign rsp.data  = rsp_data;

endmodule

>>> hdl/ira_checker.sv
// ira_checker: port-level assertions of the identifier allocator and its binding
module ira_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input ira_pkg::status_t  rsp_status,
	input logic [9:0]        rsp_id,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic              cfg_data
);
	import ira_pkg::*;

	logic       en_q;
	logic [1:0] pend_q;

	// shadow of map_enabled and count of items without a delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			pend_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				en_q <= cfg_data;
			end
			pend_q <= pend_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_id))
		else $error("result changed while stalled");

	a_fail_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> (rsp_id == 10'd0))
		else $error("failed request returned nonzero id");

	a_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !en_q |-> (rsp_status == ST_DISABLED))
		else $error("request served while map disabled");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> (pend_q < 2'd2))
		else $error("more than two items in flight");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |-> (pend_q != 2'd0))
		else $error("result without a request");

endmodule

bind id_range_allocator ira_checker u_ira_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.data.status),
	.rsp_id     (rsp.data.id),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready),
	.cfg_data   (cfg.data)
);
